[hdl/afr_pkg.sv]
// afr_pkg: shared types and constants for the api frame receiver
// used by the result interface and the top level; no dependencies
`timescale 1ns / 1ps

package afr_pkg;

  localparam logic [7:0]  DELIM_BYTE    = 8'h7E;
  localparam logic [7:0]  ESC_BYTE      = 8'h7D;
  localparam logic [7:0]  ESC_XOR       = 8'h20;
  localparam logic [7:0]  TYPE_RESET    = 8'h90;
  localparam logic [7:0]  SUM_BASE      = 8'hFF;
  localparam logic [15:0] HDR_LEN       = 16'd12;
  localparam logic [15:0] MIN_LEN       = 16'd13;
  localparam logic [15:0] ADDR64_BYTES  = 16'd8;
  localparam logic [15:0] ADDR16_BYTES  = 16'd2;
  localparam int unsigned HEAD_DEPTH    = 10;
  localparam logic [15:0] HEAD_LIMIT    = 16'(HEAD_DEPTH);
  localparam int unsigned HEAD_IDX_W    = $clog2(HEAD_DEPTH);

  localparam logic [7:0]  EV_MEASURE    = 8'h01;
  localparam logic [7:0]  EV_STATE      = 8'h02;

  localparam logic [1:0]  ST_OK         = 2'd0;
  localparam logic [1:0]  ST_CSUM       = 2'd1;
  localparam logic [1:0]  ST_SHORT      = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_TYPE,
    PH_ADDR64,
    PH_ADDR16,
    PH_OPTIONS,
    PH_PAYLOAD,
    PH_CHECK
  } phase_e;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] sender_address_64;
    logic [15:0] sender_address_16;
    logic [7:0]  receive_options;
    logic [15:0] payload_length;
    logic [7:0]  ev_code;
    logic [7:0]  device_id;
    logic [31:0] temperature_bits;
    logic [31:0] millivolt_bits;
    logic [7:0]  object_state;
  } result_t;

endpackage

[hdl/afr_byte_if.sv]
// afr_byte_if: valid/ready channel carrying one raw serial byte per item
// no dependencies
`timescale 1ns / 1ps

interface afr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

[hdl/afr_result_if.sv]
// afr_result_if: valid/ready channel carrying one decoded frame result per item
// depends on afr_pkg for the result struct
`timescale 1ns / 1ps

interface afr_result_if;
  import afr_pkg::*;

  logic    valid;
  logic    ready;
  result_t result;

  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

[hdl/api_frame_receiver.sv]
// api_frame_receiver: escaped api frame parser, a result per complete or short frame
// depends on afr_pkg, afr_byte_if and afr_result_if
//
//   channel   dir  payload                      handshake
//   rx_i      in   rx_byte (8b raw byte)        valid/ready
//   res_o     out  result_t (status + fields)   valid/ready
//   cfg       in   accepted_frame_type (8b)     cfg_we_i, no wait
//
// while the skid register is empty, one byte is parsed per cycle; the frame state
// updates at the edge that takes it; a result enters the output register the cycle
// after the byte that ends a frame if that register is free or being read, else the
// skid register; input stalls only while the skid register is full
// reset clears the parser to waiting for a start delimiter and the type to 0x90
`timescale 1ns / 1ps

module api_frame_receiver (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  afr_byte_if.sink          rx_i,
  afr_result_if.source      res_o
);
  import afr_pkg::*;

  phase_e      phase_q, phase_d;
  logic        esc_q, esc_d;
  logic [15:0] len_q, len_d;
  logic [15:0] cnt_q, cnt_d;
  logic [7:0]  sum_q, sum_d;
  logic [63:0] src64_q, src64_d;
  logic [15:0] src16_q, src16_d;
  logic [7:0]  opt_q, opt_d;
  logic [7:0]  head_q [HEAD_DEPTH];
  logic [7:0]  head_d [HEAD_DEPTH];
  logic [7:0]  type_q;

  logic        out_valid_q, out_valid_d;
  result_t     out_q, out_d;
  logic        skid_valid_q, skid_valid_d;
  result_t     skid_q, skid_d;

  logic        in_fire, out_fire;
  logic [7:0]  raw, b;
  logic        res_valid;
  result_t     res;
  logic [15:0] cnt_inc;
  logic [15:0] pay_len;
  logic [7:0]  expect_sum;

  assign in_fire  = rx_i.valid && rx_i.ready;
  assign out_fire = out_valid_q && res_o.ready;
  assign raw      = rx_i.rx_byte;
  assign b        = esc_q ? (raw ^ ESC_XOR) : raw;
  assign cnt_inc  = cnt_q + 16'd1;
  assign pay_len  = len_q - HDR_LEN;
  assign expect_sum = SUM_BASE - sum_q;

  assign rx_i.ready   = !skid_valid_q;
  assign res_o.valid  = out_valid_q;
  assign res_o.result = out_q;

  // frame parser
  always_comb begin
    phase_d   = phase_q;
    esc_d     = esc_q;
    len_d     = len_q;
    cnt_d     = cnt_q;
    sum_d     = sum_q;
    src64_d   = src64_q;
    src16_d   = src16_q;
    opt_d     = opt_q;
    head_d    = head_q;
    res_valid = 1'b0;
    res       = '0;

    if (in_fire) begin
      if (raw == DELIM_BYTE) begin
        // a raw delimiter restarts the frame, even after an escape
        phase_d = PH_LEN_HI;
        esc_d   = 1'b0;
        len_d   = '0;
        cnt_d   = '0;
        sum_d   = '0;
        src64_d = '0;
        src16_d = '0;
        opt_d   = '0;
        for (int i = 0; i < HEAD_DEPTH; i++) begin
          head_d[i] = '0;
        end
      end else if (!esc_q && raw == ESC_BYTE) begin
        esc_d = 1'b1;
      end else begin
        esc_d = 1'b0;
        case (phase_q)
          PH_LEN_HI: begin
            len_d   = {b, 8'h00};
            phase_d = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            len_d   = {len_q[15:8], b};
            phase_d = PH_TYPE;
          end
          PH_TYPE: begin
            sum_d = sum_q + b;
            if (b != type_q) begin
              phase_d = PH_IDLE;
            end else if (len_q < MIN_LEN) begin
              res_valid  = 1'b1;
              res.status = ST_SHORT;
              phase_d    = PH_IDLE;
            end else begin
              cnt_d   = '0;
              phase_d = PH_ADDR64;
            end
          end
          PH_ADDR64: begin
            sum_d   = sum_q + b;
            src64_d = {src64_q[55:0], b};
            cnt_d   = cnt_inc;
            if (cnt_inc >= ADDR64_BYTES) begin
              cnt_d   = '0;
              phase_d = PH_ADDR16;
            end
          end
          PH_ADDR16: begin
            sum_d   = sum_q + b;
            src16_d = {src16_q[7:0], b};
            cnt_d   = cnt_inc;
            if (cnt_inc >= ADDR16_BYTES) begin
              cnt_d   = '0;
              phase_d = PH_OPTIONS;
            end
          end
          PH_OPTIONS: begin
            sum_d   = sum_q + b;
            opt_d   = b;
            cnt_d   = '0;
            phase_d = PH_PAYLOAD;
          end
          PH_PAYLOAD: begin
            sum_d = sum_q + b;
            if (cnt_q < HEAD_LIMIT) begin
              head_d[cnt_q[HEAD_IDX_W-1:0]] = b;
            end
            cnt_d = cnt_inc;
            if (cnt_inc >= pay_len) begin
              phase_d = PH_CHECK;
            end
          end
          PH_CHECK: begin
            res_valid             = 1'b1;
            res.status            = (expect_sum == b) ? ST_OK : ST_CSUM;
            res.sender_address_64 = src64_q;
            res.sender_address_16 = src16_q;
            res.receive_options   = opt_q;
            res.payload_length    = pay_len;
            res.ev_code           = head_q[0];
            if (head_q[0] == EV_MEASURE) begin
              res.device_id        = head_q[9];
              res.temperature_bits = {head_q[4], head_q[3], head_q[2], head_q[1]};
              res.millivolt_bits   = {head_q[8], head_q[7], head_q[6], head_q[5]};
            end
            if (head_q[0] == EV_STATE) begin
              res.object_state = head_q[1];
            end
            phase_d = PH_IDLE;
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    end
  end

  // output register with skid stage
  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (!out_valid_q || out_fire) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = res;
        out_valid_d = res_valid;
      end
    end else if (res_valid) begin
      skid_d       = res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      esc_q        <= 1'b0;
      len_q        <= '0;
      cnt_q        <= '0;
      sum_q        <= '0;
      type_q       <= TYPE_RESET;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      esc_q        <= esc_d;
      len_q        <= len_d;
      cnt_q        <= cnt_d;
      sum_q        <= sum_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
      if (cfg_we_i) begin
        type_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers, always reached through a clearing delimiter; out and skid data
  always_ff @(posedge clk_i) begin
    src64_q <= src64_d;
    src16_q <= src16_d;
    opt_q   <= opt_d;
    head_q  <= head_d;
    out_q   <= out_d;
    skid_q  <= skid_d;
  end

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds an item while the output register is empty");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.status == ST_OK || out_q.status == ST_CSUM ||
                     out_q.status == ST_SHORT))
    else $error("result carries an undefined status");

  a_short_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == ST_SHORT) |->
      (out_q.sender_address_64 == '0 && out_q.payload_length == '0))
    else $error("short-length result carries frame fields");

  a_non_measure_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.ev_code != EV_MEASURE) |->
      (out_q.temperature_bits == '0 && out_q.millivolt_bits == '0 &&
       out_q.device_id == '0))
    else $error("measurement fields set on a non-measurement event");

  a_parse_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && res_valid) |=> (phase_q == PH_IDLE))
    else $error("parser did not return to idle after a result");

endmodule
